@@ rtl/approach_velocity_command_macros.svh @@
// ----------------------------------------------------------------------------
// approach_velocity_command assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef APPROACH_VELOCITY_COMMAND_MACROS_SVH
`define APPROACH_VELOCITY_COMMAND_MACROS_SVH

// Same-cycle implication
`define AVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define AVC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/avc_pkg.sv @@
// ----------------------------------------------------------------------------
// avc_pkg
// Types, constants and the arctangent table of the approach velocity command.
// ----------------------------------------------------------------------------
package avc_pkg;

  // Number of unrolled CORDIC stages (8 to 24)
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;

  // CORDIC datapath width: |offset| < 2^24, times sqrt 2, times gain 1.647
  localparam int CW = 28;

  localparam logic [15:0] GAIN_COMP  = 16'd39797;  // 0.60725 in Q16
  localparam logic [14:0] TURN_GAIN  = 15'd30883;  // 1.2 rad/s per rad, binary angle
  localparam logic [14:0] STEER_GAIN = 15'd20589;  // 0.8 rad/s per rad, binary angle
  localparam logic [15:0] LIN_GAIN   = 16'd39322;  // 0.6 in Q16

  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Register indexes of the configuration channel
  typedef enum logic [7:0] {
    REG_HALT_RADIUS = 8'd0,
    REG_SPIN_LIMIT  = 8'd1,
    REG_LIN_CAP     = 8'd2,
    REG_ANG_CAP     = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic signed [15:0]   yaw;
  } cordic_t;

  typedef struct packed {
    logic [15:0] halt_radius;
    logic [14:0] spin_limit;
    logic [13:0] lin_cap;
    logic [14:0] ang_cap;
  } cfg_t;

endpackage

@@ rtl/avc_delta.sv @@
// ----------------------------------------------------------------------------
// avc_delta
// Offset from robot to target, folded into the right half plane.
// ----------------------------------------------------------------------------
module avc_delta
  import avc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [23:0] robot_x_i,
  input  logic signed [23:0] robot_y_i,
  input  logic signed [15:0] robot_heading_i,
  input  logic signed [23:0] target_x_i,
  input  logic signed [23:0] target_y_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cordic_t            vec_o
);

  logic              valid_q;
  logic              en;
  logic signed [24:0] dx, dy;
  logic signed [CW-1:0] dx_ext, dy_ext;
  cordic_t           vec_d, vec_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    dx     = {target_x_i[23], target_x_i} - {robot_x_i[23], robot_x_i};
    dy     = {target_y_i[23], target_y_i} - {robot_y_i[23], robot_y_i};
    dx_ext = {{(CW-25){dx[24]}}, dx};
    dy_ext = {{(CW-25){dy[24]}}, dy};
    vec_d.yaw = robot_heading_i;
    // Turn a left-half-plane vector by pi
    if (dx[24]) begin
      vec_d.x = -dx_ext;
      vec_d.y = -dy_ext;
      vec_d.z = 32'h80000000;
    end else begin
      vec_d.x = dx_ext;
      vec_d.y = dy_ext;
      vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

@@ rtl/avc_cordic.sv @@
// ----------------------------------------------------------------------------
// avc_cordic
// Unrolled CORDIC vectoring pipeline, one register stage per iteration.
// ----------------------------------------------------------------------------
module avc_cordic
  import avc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  cordic_t vec_i,
  output logic    valid_o,
  input  logic    ready_i,
  output cordic_t vec_o
);

  cordic_t stage_q [CORDIC_STAGES];
  logic    vld_q   [CORDIC_STAGES];
  cordic_t src     [CORDIC_STAGES+1];
  logic    src_vld [CORDIC_STAGES+1];
  logic    rdy     [CORDIC_STAGES+1];

  assign src[0]               = vec_i;
  assign src_vld[0]           = valid_i;
  assign rdy[CORDIC_STAGES]   = ready_i;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [CW-1:0] xi, yi, xs, ys;
    logic                 en;
    cordic_t              nxt;

    assign en     = !vld_q[k] || rdy[k+1];
    assign rdy[k] = en;

    always_comb begin
      xi = $signed(src[k].x);
      yi = $signed(src[k].y);
      xs = xi >>> k;
      ys = yi >>> k;
      nxt.yaw = src[k].yaw;
      // Rotate toward y = 0
      if (!yi[CW-1] && (yi != '0)) begin
        nxt.x = xi + ys;
        nxt.y = yi - xs;
        nxt.z = src[k].z + ATAN_TAB[k];
      end else begin
        nxt.x = xi - ys;
        nxt.y = yi + xs;
        nxt.z = src[k].z - ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en && src_vld[k]) begin
        stage_q[k] <= nxt;
      end
    end

    assign src[k+1]     = stage_q[k];
    assign src_vld[k+1] = vld_q[k];
  end

  assign ready_o = rdy[0];
  assign valid_o = src_vld[CORDIC_STAGES];
  assign vec_o   = src[CORDIC_STAGES];

endmodule

@@ rtl/avc_law.sv @@
// ----------------------------------------------------------------------------
// avc_law
// Distance scaling, heading error, case selection, gains and saturation.
// ----------------------------------------------------------------------------
module avc_law
  import avc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  cordic_t            vec_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic               reached_o,
  output logic [13:0]        linear_speed_o,
  output logic signed [15:0] angular_speed_o
);

  // Stage 1: distance and heading error
  logic               v1_q, en1;
  logic [CW-2:0]      xp;
  logic [CW+15:0]     dprod;
  logic [31:0]        zr;
  logic [CW-2:0]      dist_d, dist_q;
  logic [15:0]        err_d, err_q;

  // Stage 2: case selection and magnitudes
  logic               v2_q, en2;
  logic               reached_d, reached2_q;
  logic               turn_d, turn_q;
  logic               sign2_q;
  logic [15:0]        amag_d, amag_q;
  logic [CW-2:0]      lin_op_d, lin_op_q;

  // Stage 3: gain products
  logic               v3_q, en3;
  logic               reached3_q, sign3_q;
  logic [30:0]        ang_p_q;
  logic [CW+15:0]     lin_p_q;
  logic [14:0]        gain;

  // Stage 4: rounding, saturation, output register
  logic               v4_q, en4;
  logic [30:0]        ang_s;
  logic [CW+15:0]     lin_s;
  logic [14:0]        ang_r, ang_c;
  logic [CW-2:0]      lin_r;
  logic [13:0]        lin_c;
  logic               reached4_q;
  logic [13:0]        lin4_q;
  logic signed [15:0] ang4_q;
  logic signed [15:0] ang_d;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    xp     = vec_i.x[CW-1] ? '0 : vec_i.x[CW-2:0];
    dprod  = (CW+16)'(xp) * (CW+16)'(GAIN_COMP) + (CW+16)'(32768);
    dist_d = dprod[CW+14:16];
    zr     = vec_i.z + 32'h00008000;
    err_d  = zr[31:16] - vec_i.yaw;
  end

  always_comb begin
    reached_d = dist_q <= (CW-1)'(cfg_i.halt_radius);
    amag_d    = err_q[15] ? 16'(-err_q) : err_q;
    turn_d    = amag_d > 16'(cfg_i.spin_limit);
    lin_op_d  = (reached_d || turn_d) ? '0 : dist_q - (CW-1)'(cfg_i.halt_radius);
  end

  assign gain = turn_q ? TURN_GAIN : STEER_GAIN;

  always_comb begin
    ang_s = ang_p_q + 31'd32768;
    lin_s = lin_p_q + (CW+16)'(32768);
    ang_r = ang_s[30:16];
    lin_r = lin_s[CW+14:16];
    lin_c = (lin_r > (CW-1)'(cfg_i.lin_cap)) ? cfg_i.lin_cap : lin_r[13:0];
    ang_c = (ang_r > cfg_i.ang_cap) ? cfg_i.ang_cap : ang_r;
    ang_d = sign3_q ? -$signed({1'b0, ang_c}) : $signed({1'b0, ang_c});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      dist_q <= dist_d;
      err_q  <= err_d;
    end
    if (en2 && v1_q) begin
      reached2_q <= reached_d;
      turn_q     <= turn_d;
      sign2_q    <= err_q[15];
      amag_q     <= reached_d ? '0 : amag_d;
      lin_op_q   <= lin_op_d;
    end
    if (en3 && v2_q) begin
      reached3_q <= reached2_q;
      sign3_q    <= sign2_q;
      ang_p_q    <= 31'(amag_q) * 31'(gain);
      lin_p_q    <= (CW+16)'(lin_op_q) * (CW+16)'(LIN_GAIN);
    end
    if (en4 && v3_q) begin
      reached4_q <= reached3_q;
      lin4_q     <= reached3_q ? '0 : lin_c;
      ang4_q     <= reached3_q ? '0 : ang_d;
    end
  end

  assign valid_o         = v4_q;
  assign reached_o       = reached4_q;
  assign linear_speed_o  = lin4_q;
  assign angular_speed_o = ang4_q;

endmodule

@@ rtl/approach_velocity_command.sv @@
// ----------------------------------------------------------------------------
// approach_velocity_command
// Proportional go-to-goal drive command from robot pose and target point.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                     Content
//  s_axis    in         s_axis_tvalid/s_axis_tready   pose and target, one beat
//  m_axis    out        m_axis_tvalid/m_axis_tready   speeds in tdata, reached in tuser
//  cfg       in         cfg_valid_i/cfg_ready_o       register index and value
//
//  A beat may enter on every cycle unless the pipe is full and stalled; the
//  stages are the front fold stage, the CORDIC stages and four law stages.
//  Reset clears the valid bits and loads the register defaults; no pass needed.
//  Each stage holds while the stage after it is full and stalled, so bubbles
//  close up and input is still taken while a result waits at the output.
//  Configuration is always ready and must only change with the pipe empty.
//
module approach_velocity_command
  import avc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Pose and target
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [23:0] robot_x, [47:24] robot_y, [63:48] robot_heading,
  // [87:64] target_x, [111:88] target_y
  input  logic [111:0] s_axis_tdata,
  // Drive command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [13:0] linear_speed, [29:14] angular_speed, [31:30] zero
  output logic [31:0]  m_axis_tdata,
  // [0] reached
  output logic         m_axis_tuser,
  // Configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

`include "approach_velocity_command_macros.svh"

  cfg_t cfg_d, cfg_q;

  logic    d_valid, d_ready;
  cordic_t d_vec;
  logic    c_valid, c_ready;
  cordic_t c_vec;

  logic               reached;
  logic [13:0]        linear_speed;
  logic signed [15:0] angular_speed;
  logic [15:0]        ang_abs;

  // Register file: take a write on any cycle, drop unknown indexes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HALT_RADIUS: cfg_d.halt_radius = cfg_data_i;
        REG_SPIN_LIMIT:  cfg_d.spin_limit  = cfg_data_i[14:0];
        REG_LIN_CAP:     cfg_d.lin_cap     = cfg_data_i[13:0];
        REG_ANG_CAP:     cfg_d.ang_cap     = cfg_data_i[14:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.halt_radius <= 16'd1229;
      cfg_q.spin_limit  <= 15'd5461;
      cfg_q.lin_cap     <= 14'd1229;
      cfg_q.ang_cap     <= 15'd4096;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Fold the offset into the right half plane
  avc_delta u_delta (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s_axis_tvalid),
    .ready_o         (s_axis_tready),
    .robot_x_i       ($signed(s_axis_tdata[23:0])),
    .robot_y_i       ($signed(s_axis_tdata[47:24])),
    .robot_heading_i ($signed(s_axis_tdata[63:48])),
    .target_x_i      ($signed(s_axis_tdata[87:64])),
    .target_y_i      ($signed(s_axis_tdata[111:88])),
    .valid_o         (d_valid),
    .ready_i         (d_ready),
    .vec_o           (d_vec)
  );

  // Distance and bearing
  avc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .ready_o (d_ready),
    .vec_i   (d_vec),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .vec_o   (c_vec)
  );

  // Steering law and output register
  avc_law u_law (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .valid_i         (c_valid),
    .ready_o         (c_ready),
    .vec_i           (c_vec),
    .valid_o         (m_axis_tvalid),
    .ready_i         (m_axis_tready),
    .reached_o       (reached),
    .linear_speed_o  (linear_speed),
    .angular_speed_o (angular_speed)
  );

  assign m_axis_tdata = {2'b00, angular_speed, linear_speed};
  assign m_axis_tuser = reached;

  assign ang_abs = angular_speed[15] ? 16'(-angular_speed) : angular_speed;

  `AVC_ASSERT_IMP(a_reached_halts, m_axis_tvalid && reached,
    (linear_speed == 14'd0) && (angular_speed == 16'sd0),
    "reached result carries non-zero speed")
  `AVC_ASSERT_IMP(a_lin_sat, m_axis_tvalid,
    linear_speed <= cfg_q.lin_cap,
    "linear speed above its limit")
  `AVC_ASSERT_IMP(a_ang_sat, m_axis_tvalid,
    ang_abs <= {1'b0, cfg_q.ang_cap},
    "angular speed above its limit")
  `AVC_ASSERT_NXT(a_cfg_lin_write,
    cfg_valid_i && (cfg_index_i == REG_LIN_CAP),
    cfg_q.lin_cap == $past(cfg_data_i[13:0]),
    "linear speed limit write not taken")

endmodule

@@ test/tb_approach_velocity_command.sv @@
// ----------------------------------------------------------------------------
// tb_approach_velocity_command
// Self-checking bench for the go-to-goal drive command block. A clocked driver
// streams pose/target beats from a queue, a clocked monitor compares every
// drive command against a bit-true predictor of the CORDIC and control law.
// ----------------------------------------------------------------------------
module tb_approach_velocity_command;
  timeunit 1ns;
  timeprecision 1ps;

  import avc_pkg::*;

  // Indexes past the register map
  localparam logic [7:0] REG_COUNT             = 8'd4;
  localparam logic [7:0] REG_INDEX_TOP         = 8'hFF;

  localparam cfg_t CFG_RESET = '{16'd1229, 15'd5461, 14'd1229, 15'd4096};

  localparam int LATENCY         = CORDIC_STAGES + 5;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 6;
  localparam int POSES_PER_PHASE = 292;
  localparam int POS_MAX         = 8388607;
  localparam int POS_MIN         = -8388608;
  localparam int FAULTS_SHOWN    = 10;

  // Packed to match s_axis_tdata, robot_x in the lowest bits
  typedef struct packed {
    logic signed [23:0] target_y;
    logic signed [23:0] target_x;
    logic signed [15:0] robot_heading;
    logic signed [23:0] robot_y;
    logic signed [23:0] robot_x;
  } pose_t;

  typedef struct packed {
    logic               reached;
    logic [13:0]        linear;
    logic signed [15:0] angular;
  } cmd_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [23:0] robot_x, [47:24] robot_y, [63:48] robot_heading,
  // [87:64] target_x, [111:88] target_y
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [13:0] linear_speed, [29:14] angular_speed, [31:30] zero
  logic [31:0]  m_axis_tdata;
  // [0] reached
  logic         m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  pose_t pending_poses[$];
  cmd_t  expected_cmds[$];
  cfg_t  cfg_model = CFG_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req_cnt  = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int fault_count   = 0;
  int poses_sent    = 0;
  int cmds_checked  = 0;
  int n_reached     = 0;
  int n_moving      = 0;
  int n_settings    = 1;

  approach_velocity_command dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Vectoring CORDIC: fold the left half-plane by pi, then rotate onto the
  // x axis. Shifts floor, the angle wraps on 32 bits.
  function automatic void vector_polar(input longint dx, input longint dy,
                                       output longint radius, output logic [15:0] bearing);
    longint      x, y, xs, ys;
    logic [31:0] z, zr;
    x = dx;
    y = dy;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end
    end
    if (x < 0) x = 0;
    radius = (x * longint'(GAIN_COMP) + 32768) >>> 16;
    zr = z + 32'h0000_8000;
    bearing = zr[31:16];
  endfunction

  // Scale by a Q16 gain, rounding half away from zero
  function automatic longint scale_q16(longint v, longint gain);
    longint mag, r;
    mag = (v < 0) ? -v : v;
    r = (mag * gain + 32768) >>> 16;
    return (v < 0) ? -r : r;
  endfunction

  function automatic cmd_t predict_command(pose_t p);
    longint      radius, err, lin, ang, amax, lmax, stop, thr;
    logic [15:0] bearing, err_w;
    cmd_t        c;
    amax = longint'(cfg_model.ang_cap);
    lmax = longint'(cfg_model.lin_cap);
    stop = longint'(cfg_model.halt_radius);
    thr  = longint'(cfg_model.spin_limit);
    vector_polar(longint'(p.target_x) - longint'(p.robot_x),
                 longint'(p.target_y) - longint'(p.robot_y), radius, bearing);
    err_w = bearing - p.robot_heading;
    err = longint'(signed'(err_w));
    c = '0;
    if (radius <= stop) begin
      c.reached = 1'b1;
      return c;
    end
    if (((err < 0) ? -err : err) > thr) begin
      // heading too far off: rotate on the spot
      lin = 0;
      ang = scale_q16(err, longint'(TURN_GAIN));
    end else begin
      lin = scale_q16(radius - stop, longint'(LIN_GAIN));
      if (lin > lmax) lin = lmax;
      if (lin < 0) lin = 0;
      ang = scale_q16(err, longint'(STEER_GAIN));
    end
    if (ang > amax) ang = amax;
    if (ang < -amax) ang = -amax;
    c.linear  = lin[13:0];
    c.angular = ang[15:0];
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Mostly a target at a random scale from the robot, often with the heading
  // close to the bearing so the drive branch is reached; some pure noise.
  function automatic pose_t make_pose();
    pose_t       p;
    logic [31:0] r;
    int unsigned span;
    longint      tx, ty, radius;
    logic [15:0] bearing;
    r = $urandom(); p.robot_x = r[23:0];
    r = $urandom(); p.robot_y = r[23:0];
    r = $urandom(); p.robot_heading = r[15:0];
    r = $urandom(); p.target_x = r[23:0];
    r = $urandom(); p.target_y = r[23:0];
    if ($urandom_range(0, 99) < 15) return p;
    span = $urandom_range(0, 23);
    tx = clamp_pos(longint'(p.robot_x) + longint'($urandom_range(0, (2 << span) - 1))
                   - (longint'(1) << span));
    span = $urandom_range(0, 23);
    ty = clamp_pos(longint'(p.robot_y) + longint'($urandom_range(0, (2 << span) - 1))
                   - (longint'(1) << span));
    p.target_x = tx[23:0];
    p.target_y = ty[23:0];
    if ($urandom_range(0, 99) < 65) begin
      vector_polar(tx - longint'(p.robot_x), ty - longint'(p.robot_y), radius, bearing);
      r = $urandom_range(0, 16383);
      p.robot_heading = bearing + r[15:0] - 16'd8192;
    end
    return p;
  endfunction

  task automatic add_pose(int rx, int ry, int yaw, int tx, int ty);
    pose_t p;
    p.robot_x       = rx[23:0];
    p.robot_y       = ry[23:0];
    p.robot_heading = yaw[15:0];
    p.target_x      = tx[23:0];
    p.target_y      = ty[23:0];
    pending_poses.push_back(p);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HALT_RADIUS: cfg_model.halt_radius = val;
      REG_SPIN_LIMIT:  cfg_model.spin_limit  = val[14:0];
      REG_LIN_CAP:     cfg_model.lin_cap     = val[13:0];
      REG_ANG_CAP:     cfg_model.ang_cap     = val[14:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] stop, logic [15:0] thr, logic [15:0] lmax,
                           logic [15:0] amax);
    write_reg(REG_HALT_RADIUS, stop);
    write_reg(REG_SPIN_LIMIT, thr);
    write_reg(REG_LIN_CAP, lmax);
    write_reg(REG_ANG_CAP, amax);
    n_settings++;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Wait for the pipe to empty, then let the tail of the latency run out
  task automatic drain_pipe();
    do @(negedge clk_i);
    while (pending_poses.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic report_fault(string what);
    fault_count++;
    if (fault_count <= FAULTS_SHOWN) $display("[%0t] %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Driver: hold a beat until taken, predict the command on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_poses
    logic         next_valid;
    logic [111:0] next_data;
    next_valid = s_axis_tvalid;
    next_data  = s_axis_tdata;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_cmds.push_back(predict_command(pose_t'(s_axis_tdata)));
        poses_sent++;
        next_valid = 1'b0;
      end
      // idle only between beats, never drop a beat on offer
      if (!next_valid && pending_poses.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        next_data  = pending_poses.pop_front();
        next_valid = 1'b1;
      end
    end
    s_axis_tvalid <= next_valid;
    s_axis_tdata  <= next_data;
  end

  // --------------------------------------------------------------------------
  // Monitor: check each command beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_commands
    cmd_t want;
    logic next_ready;
    next_ready = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cmds.size() == 0) begin
          report_fault($sformatf("command beat with nothing expected: tdata %h tuser %b",
                                 m_axis_tdata, m_axis_tuser));
        end else begin
          want = expected_cmds.pop_front();
          cmds_checked++;
          if (want.reached) n_reached++;
          else if (want.linear != 0) n_moving++;
          if (m_axis_tuser !== want.reached || m_axis_tdata[13:0] !== want.linear ||
              m_axis_tdata[29:14] !== want.angular || m_axis_tdata[31:30] !== 2'b00) begin
            report_fault($sformatf(
              "command %0d mismatch: expected reached %b lin %0d ang %0d, got %b %0d %0d (%h)",
              cmds_checked, want.reached, want.linear, want.angular, m_axis_tuser,
              m_axis_tdata[13:0], $signed(m_axis_tdata[29:14]), m_axis_tdata));
          end
        end
      end
      // a long hold-off lets the pipe fill and back up into the input
      if (hold_ack != hold_req_cnt) begin
        hold_ack  = hold_req_cnt;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) hold_left--;
      else next_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
    m_axis_tready <= next_ready;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("approach_velocity_command test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    logic [31:0] r0, r1;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats against the register defaults
    set_idling(33, 71);
    @(negedge clk_i);
    add_pose(0, 0, 0, 0, 0);                            // robot on the target
    add_pose(POS_MAX, POS_MAX, 32767, POS_MAX, POS_MAX);
    add_pose(POS_MIN, POS_MIN, -32768, POS_MAX, POS_MAX); // largest positive offset
    add_pose(POS_MAX, POS_MAX, 0, POS_MIN, POS_MIN);      // largest negative offset
    add_pose(0, 0, 0, 1228, 0);                         // either side of stop distance
    add_pose(0, 0, 0, 1229, 0);
    add_pose(0, 0, 0, 1230, 0);
    add_pose(0, 0, 0, 1235, 0);
    add_pose(0, 0, -32768, 100000, 0);                  // heading error of minus pi
    add_pose(0, 0, 32767, 100000, 0);
    add_pose(0, 0, 16384, 100000, 0);                   // turn in place
    add_pose(0, 0, 0, 100000, 0);                       // forward speed saturates
    add_pose(0, 0, 100, 3000, 0);
    add_pose(0, 0, -100, 3000, 0);
    add_pose(0, 0, 0, -50000, 0);                       // left half-plane fold
    add_pose(0, 0, 0, -50000, 3);
    add_pose(0, 0, 0, -50000, -3);
    add_pose(0, 0, 16384, 0, 50000);                    // straight up and down
    add_pose(0, 0, -16384, 0, -50000);
    add_pose(5000, -7000, 5461, 9000, -3000);
    add_pose(POS_MIN, 0, 0, POS_MAX, 0);
    add_pose(0, POS_MIN, 16384, 0, POS_MAX);
    drain_pipe();

    // Writes to missing registers must leave the settings alone
    write_reg(REG_COUNT, 16'hFFFF);
    write_reg(REG_INDEX_TOP, 16'h0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_all(16'd1229, 16'd5461, 16'd1229, 16'd4096);
        1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: write_all(16'd0, 16'd0, 16'd0, 16'd0);
        4: write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: begin
          r0 = $urandom();
          r1 = $urandom();
          write_all(r0[15:0], r0[31:16], r1[15:0], r1[31:16]);
        end
      endcase
      if (phase < 2) set_idling(33, 71);
      else if (phase < 4) set_idling(71, 33);
      else set_idling(0, 0);
      @(negedge clk_i);
      for (int k = 0; k < POSES_PER_PHASE; k++) pending_poses.push_back(make_pose());
      if (phase == 4) begin
        @(posedge clk_i);
        hold_req_cnt <= hold_req_cnt + 1;
      end
      drain_pipe();
    end

    if (expected_cmds.size() != 0)
      report_fault($sformatf("%0d commands never arrived", expected_cmds.size()));

    $display("Sent %0d pose beats under %0d register settings, checked %0d commands.",
             poses_sent, n_settings, cmds_checked);
    $display("Commands: %0d reached, %0d driving forward, %0d turning or at rest; %0d faults.",
             n_reached, n_moving, cmds_checked - n_reached - n_moving, fault_count);
    if (fault_count == 0) begin
      $display("approach_velocity_command test passed");
    end else begin
      $display("approach_velocity_command test failed");
    end
    $finish;
  end

endmodule
